[hdl/ebg_pkg.sv]
// Shared types, constants and reciprocal table for the elliptical Gaussian beam gain pipeline.
package ebg_pkg;

  localparam int DIST_W = 32;
  localparam int FREQ_W = 36;
  localparam int FW_W   = 40;
  localparam int D_W    = 33;
  localparam int Z_W    = 38;
  localparam int ZS_W   = 39;

  localparam logic [28:0] LIGHT_SPEED        = 29'd299792458;
  localparam logic [30:0] HALF_PI_Q30        = 31'd1686629713;
  localparam logic [31:0] FWHM_PER_SIGMA_Q30 = 32'd2528468770;
  localparam logic [31:0] LN2_Q32            = 32'd2977044472;
  localparam logic [30:0] ONE_Q30            = 31'h4000_0000;
  localparam logic [32:0] ONE_Q32            = 33'h1_0000_0000;
  localparam logic [FW_W-1:0] FW_CAP         = 40'hFF_FFFF_FFFF;
  localparam logic [Z_W-1:0]  Z_CAP          = 38'b1 << 37;

  typedef enum logic [2:0] {
    REG_APERTURE,
    REG_WIDTH_SCALING,
    REG_EXP_SCALING,
    REG_SIGMA_X,
    REG_SIGMA_Y,
    REG_ROTATION,
    REG_CENTRE_X,
    REG_CENTRE_Y
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] aperture;
    logic [19:0] wscale;
    logic [19:0] kscale;
    logic [31:0] sigx;
    logic [31:0] sigy;
    logic [15:0] rot;
    logic [31:0] cx;
    logic [31:0] cy;
  } cfg_t;

  typedef struct packed {
    logic [15:0]       pa;
    logic [DIST_W-1:0] offs;
    logic [FREQ_W-1:0] freq;
    logic [FW_W-1:0]   fwf;
    logic [D_W-1:0]    dx;
    logic [D_W-1:0]    dy;
    logic [Z_W-1:0]    zx;
    logic [Z_W-1:0]    zy;
    logic              err;
  } item_t;

  // floor(2^32 / d) for the small divisors of the series evaluations
  function automatic logic [32:0] recip_of(input logic [7:0] d);
    logic [32:0] r;
    case (d)
      8'd156:  r = 33'd27531841;
      8'd110:  r = 33'd39045157;
      8'd72:   r = 33'd59652323;
      8'd42:   r = 33'd102261126;
      8'd20:   r = 33'd214748364;
      8'd12:   r = 33'd357913941;
      8'd11:   r = 33'd390451572;
      8'd10:   r = 33'd429496729;
      8'd9:    r = 33'd477218588;
      8'd8:    r = 33'd536870912;
      8'd7:    r = 33'd613566756;
      8'd6:    r = 33'd715827882;
      8'd5:    r = 33'd858993459;
      8'd4:    r = 33'd1073741824;
      8'd3:    r = 33'd1431655765;
      8'd2:    r = 33'd2147483648;
      8'd1:    r = 33'h1_0000_0000;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/ebg_if.sv]
// Request and result channel interfaces.
interface ebg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position_angle;
  logic [31:0] offset_distance;
  logic [35:0] frequency_hz;
  modport source (output valid, position_angle, offset_distance, frequency_hz, input ready);
  modport sink (input valid, position_angle, offset_distance, frequency_hz, output ready);
endinterface

interface ebg_out_if #(parameter int GAIN_FRAC_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [GAIN_FRAC_BITS:0] gain;
  logic                    width_error;
  modport source (output valid, gain, width_error, input ready);
  modport sink (input valid, gain, width_error, output ready);
endinterface

[hdl/ebg_fwhm.sv]
// Frequency-derived beam width: c*scaling/(aperture*frequency) by a pipelined restoring divider.
module ebg_fwhm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ebg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  ebg_pkg::item_t in_item,
  output logic           out_valid,
  output ebg_pkg::item_t out_item
);
  import ebg_pkg::*;

  localparam int STEPS = FW_W;

  logic [48:0] nprod;
  logic        v1, v2;
  item_t       it1, it2;
  logic [49:0] pp_lo, pp_hi;
  logic [67:0] den2;
  item_t       last_item;

  logic [67:0]     rem  [0:STEPS];
  logic [67:0]     den  [0:STEPS];
  logic [FW_W-1:0] qn   [0:STEPS];
  logic            ovf  [0:STEPS];
  logic            zro  [0:STEPS];
  logic            vv   [0:STEPS];
  item_t           itv  [0:STEPS];

  always_ff @(posedge clk) begin
    nprod <= 49'(cfg.wscale) * 49'(LIGHT_SPEED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      vv[0] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      vv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1    <= in_item;
      pp_lo  <= 50'(cfg.aperture) * 50'(in_item.freq[17:0]);
      pp_hi  <= 50'(cfg.aperture) * 50'(in_item.freq[35:18]);
      it2    <= it1;
      den2   <= 68'(pp_lo) + {pp_hi, 18'b0};
      itv[0] <= it2;
      den[0] <= den2;
      zro[0] <= (den2 == 68'd0);
      // quotient of 2^40 or more saturates
      ovf[0] <= {29'b0, nprod} >= {den2, 10'b0};
      rem[0] <= 68'(nprod[48:10]);
      qn[0]  <= {nprod[9:0], 30'b0};
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [68:0] r2;
    logic        ge;
    assign r2 = {rem[j], qn[j][FW_W-1]};
    assign ge = r2 >= {1'b0, den[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j+1] <= 1'b0;
      end else if (en) begin
        vv[j+1] <= vv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? 68'(r2 - {1'b0, den[j]}) : r2[67:0];
        qn[j+1]  <= {qn[j][FW_W-2:0], ge};
        den[j+1] <= den[j];
        ovf[j+1] <= ovf[j];
        zro[j+1] <= zro[j];
        itv[j+1] <= itv[j];
      end
    end
  end

  always_comb begin
    last_item     = itv[STEPS];
    last_item.fwf = zro[STEPS] ? '0 : (ovf[STEPS] ? FW_CAP : qn[STEPS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= last_item;
    end
  end

endmodule

[hdl/ebg_trig.sv]
// Rotation of the offset onto the beam axes: sine series per lane, projection, centre subtract.
module ebg_trig (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ebg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  ebg_pkg::item_t in_item,
  output logic           out_valid,
  output ebg_pkg::item_t out_item
);
  import ebg_pkg::*;

  localparam int LAT   = 23;
  localparam int HSUB  = 18;

  logic           cv [0:LAT];
  item_t          ci [0:LAT];
  logic [D_W-1:0] dmag [0:1];
  logic [15:0]    theta;

  assign cv[0] = in_valid;
  assign ci[0] = in_item;
  assign theta = in_item.pa - cfg.rot;

  for (genvar k = 1; k <= LAT; k++) begin : g_chain
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (en) begin
        cv[k] <= cv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ci[k] <= ci[k-1];
      end
    end
  end

  // lane 0 is the cosine axis, lane 1 the sine axis
  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam logic [15:0] OFS = (l == 0) ? 16'd16384 : 16'd0;

    logic [15:0] ang;
    logic [14:0] p;
    logic [45:0] xw;
    logic [30:0] x1;
    logic        neg1;
    logic [61:0] xx;
    logic [30:0] hx  [0:HSUB];
    logic [31:0] hx2 [0:HSUB];
    logic        hn  [0:HSUB];
    logic [62:0] h_prod [0:5];
    logic [31:0] h_a    [0:5];
    logic [31:0] h_q0   [0:5];
    logic [30:0] h_t    [0:5];
    logic [61:0] sp;
    logic [30:0] mag;
    logic        negs;
    logic [62:0] pprod;
    logic [32:0] proj;
    logic        negp;
    logic [31:0] cen;
    logic [34:0] sproj, diffv, absd;

    assign ang = theta + OFS;
    assign p   = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    assign xw  = 46'(p) * 46'(HALF_PI_Q30) + 46'd8192;
    assign xx  = 62'(x1) * 62'(x1);

    always_ff @(posedge clk) begin
      if (en) begin
        x1     <= xw[44:14];
        neg1   <= ang[15];
        hx[0]  <= x1;
        hx2[0] <= xx[61:30];
        hn[0]  <= neg1;
      end
    end

    for (genvar s = 1; s <= HSUB; s++) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          hx[s]  <= hx[s-1];
          hx2[s] <= hx2[s-1];
          hn[s]  <= hn[s-1];
        end
      end
    end

    // Horner steps for m = 6 down to 1: t = 1 - x^2*t / ((2m)(2m+1))
    for (genvar j = 0; j < 6; j++) begin : g_horner
      localparam int          M = 6 - j;
      localparam logic [7:0]  DV = 8'((2 * M) * (2 * M + 1));
      localparam logic [32:0] RC = recip_of(DV);

      logic [30:0] tin;
      logic [64:0] mq;
      logic [39:0] qd, rm;
      logic        ge;

      if (j == 0) begin : g_first
        assign tin = ONE_Q30;
      end else begin : g_next
        assign tin = h_t[j-1];
      end

      assign mq = 65'(h_prod[j][61:30]) * 65'(RC);
      assign qd = 40'(h_q0[j]) * 40'(DV);
      assign rm = 40'(h_a[j]) - qd;
      assign ge = rm >= 40'(DV);

      always_ff @(posedge clk) begin
        if (en) begin
          h_prod[j] <= 63'(hx2[3*j]) * 63'(tin);
          h_a[j]    <= h_prod[j][61:30];
          h_q0[j]   <= mq[63:32];
          h_t[j]    <= 31'(ONE_Q30 - 31'(h_q0[j]) - 31'(ge));
        end
      end
    end

    assign sp = 62'(hx[HSUB]) * 62'(h_t[5]);

    assign pprod = 63'(ci[21].offs) * 63'(mag);
    assign cen   = (l == 0) ? cfg.cx : cfg.cy;
    assign sproj = negp ? (35'd0 - {2'b0, proj}) : {2'b0, proj};
    assign diffv = sproj - {{3{cen[31]}}, cen};
    assign absd  = diffv[34] ? (35'd0 - diffv) : diffv;

    always_ff @(posedge clk) begin
      if (en) begin
        // clamp the series at one
        mag     <= (sp[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : sp[60:30];
        negs    <= hn[HSUB];
        proj    <= pprod[62:30];
        negp    <= negs;
        dmag[l] <= absd[D_W-1:0];
      end
    end
  end

  assign out_valid = cv[LAT];

  always_comb begin
    out_item    = ci[LAT];
    out_item.dx = dmag[0];
    out_item.dy = dmag[1];
  end

endmodule

[hdl/ebg_zdiv.sv]
// Per-axis normalized offset (d/fwhm) by pipelined division, squared and scaled by k.
module ebg_zdiv (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ebg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  ebg_pkg::item_t in_item,
  output logic           out_valid,
  output ebg_pkg::item_t out_item
);
  import ebg_pkg::*;

  localparam int LAT   = 37;
  localparam int STEPS = 32;

  logic            cv [0:LAT];
  item_t           ci [0:LAT];
  logic [FW_W-1:0] fwc [0:1];
  logic [Z_W-1:0]  zout [0:1];
  item_t           first_item;

  assign cv[0] = in_valid;
  assign ci[0] = in_item;

  always_comb begin
    first_item     = ci[0];
    first_item.err = (fwc[0] == '0) || (fwc[1] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[1] <= 1'b0;
    end else if (en) begin
      cv[1] <= cv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci[1] <= first_item;
    end
  end

  for (genvar k = 2; k <= LAT; k++) begin : g_chain
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (en) begin
        cv[k] <= cv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ci[k] <= ci[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0]     sig;
    logic [63:0]     sprod;
    logic [33:0]     sfw;
    logic [D_W-1:0]  dd, d1;
    logic [FW_W-1:0] fw1;
    logic [FW_W-1:0] rem [0:STEPS];
    logic [FW_W-1:0] fw  [0:STEPS];
    logic [31:0]     qn  [0:STEPS];
    logic            ovf [0:STEPS];
    logic [63:0]     uu;
    logic [55:0]     w;
    logic            ovf_w, ovf_p;
    logic [47:0]     plo, phi;
    logic [75:0]     prod;
    logic [59:0]     zt;

    assign sig   = (l == 0) ? cfg.sigx : cfg.sigy;
    assign sprod = 64'(sig) * 64'(FWHM_PER_SIGMA_Q30);
    assign dd    = (l == 0) ? ci[0].dx : ci[0].dy;
    assign fwc[l] = (sig != 32'd0) ? 40'(sfw) : ci[0].fwf;

    always_ff @(posedge clk) begin
      sfw <= sprod[63:30];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fw1    <= fwc[l];
        d1     <= dd;
        fw[0]  <= fw1;
        // quotient of 2^32 or more saturates
        ovf[0] <= 40'(d1[32:12]) >= fw1;
        rem[0] <= 40'(d1[32:12]);
        qn[0]  <= {d1[11:0], 20'b0};
      end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [FW_W:0] r2;
      logic          ge;
      assign r2 = {rem[j], qn[j][31]};
      assign ge = r2 >= {1'b0, fw[j]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? FW_W'(r2 - {1'b0, fw[j]}) : r2[FW_W-1:0];
          qn[j+1]  <= {qn[j][30:0], ge};
          fw[j+1]  <= fw[j];
          ovf[j+1] <= ovf[j];
        end
      end
    end

    assign uu   = 64'(qn[STEPS]) * 64'(qn[STEPS]);
    assign prod = 76'(plo) + {phi, 28'b0};
    assign zt   = prod[75:16];

    always_ff @(posedge clk) begin
      if (en) begin
        w       <= uu[63:8];
        ovf_w   <= ovf[STEPS];
        plo     <= 48'(w[27:0]) * 48'(cfg.kscale);
        phi     <= 48'(w[55:28]) * 48'(cfg.kscale);
        ovf_p   <= ovf_w;
        if (cfg.kscale == 20'd0) begin
          zout[l] <= '0;
        end else if (ovf_p || zt > 60'(Z_CAP)) begin
          zout[l] <= Z_CAP;
        end else begin
          zout[l] <= zt[Z_W-1:0];
        end
      end
    end
  end

  assign out_valid = cv[LAT];

  always_comb begin
    out_item    = ci[LAT];
    out_item.zx = zout[0];
    out_item.zy = zout[1];
  end

endmodule

[hdl/ebg_exp.sv]
// exp(-(zx+zy)): reduce by ln2, series on the remainder, rounded shift into the result register.
module ebg_exp #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  ebg_pkg::item_t          in_item,
  output logic                    out_valid,
  output logic [GAIN_FRAC_BITS:0] gain,
  output logic                    width_error
);
  import ebg_pkg::*;

  localparam int LAT  = 45;
  localparam int HSUB = 36;

  logic cv [0:LAT];
  logic ce [0:LAT];

  logic [ZS_W-1:0] rr [0:7];
  logic [6:0]      nn [0:7];
  logic [31:0]     hr [0:HSUB];
  logic [6:0]      hn [0:HSUB];
  logic [64:0]     h_prod [0:11];
  logic [31:0]     h_a    [0:11];
  logic [31:0]     h_q0   [0:11];
  logic [32:0]     h_t    [0:11];

  logic [7:0]  shv;
  logic [63:0] rnd, sumv, resv;

  assign cv[0] = in_valid;
  assign ce[0] = in_item.err;

  for (genvar k = 1; k <= LAT; k++) begin : g_chain
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (en) begin
        cv[k] <= cv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ce[k] <= ce[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= ZS_W'(in_item.zx) + ZS_W'(in_item.zy);
      nn[0] <= '0;
    end
  end

  // one quotient bit of Z / ln2 per stage
  for (genvar j = 0; j < 7; j++) begin : g_reduce
    localparam logic [ZS_W-1:0] CMPV = ZS_W'(LN2_Q32) << (6 - j);
    logic ge;
    assign ge = rr[j] >= CMPV;
    always_ff @(posedge clk) begin
      if (en) begin
        rr[j+1] <= ge ? rr[j] - CMPV : rr[j];
        nn[j+1] <= {nn[j][5:0], ge};
      end
    end
  end

  assign hr[0] = rr[7][31:0];
  assign hn[0] = nn[7];

  for (genvar s = 1; s <= HSUB; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        hr[s] <= hr[s-1];
        hn[s] <= hn[s-1];
      end
    end
  end

  // Horner steps for i = 12 down to 1: t = 1 - r*t / i
  for (genvar j = 0; j < 12; j++) begin : g_horner
    localparam logic [7:0]  DV = 8'(12 - j);
    localparam logic [32:0] RC = recip_of(DV);

    logic [32:0] tin;
    logic [64:0] mq;
    logic [39:0] qd, rm;
    logic        ge;

    if (j == 0) begin : g_first
      assign tin = ONE_Q32;
    end else begin : g_next
      assign tin = h_t[j-1];
    end

    assign mq = 65'(h_prod[j][63:32]) * 65'(RC);
    assign qd = 40'(h_q0[j]) * 40'(DV);
    assign rm = 40'(h_a[j]) - qd;
    assign ge = rm >= 40'(DV);

    always_ff @(posedge clk) begin
      if (en) begin
        h_prod[j] <= 65'(hr[3*j]) * 65'(tin);
        h_a[j]    <= h_prod[j][63:32];
        h_q0[j]   <= mq[63:32];
        h_t[j]    <= 33'(ONE_Q32 - 33'(h_q0[j]) - 33'(ge));
      end
    end
  end

  assign shv  = 8'(32 - GAIN_FRAC_BITS) + {1'b0, hn[HSUB]};
  assign rnd  = 64'd1 << (shv[5:0] - 6'd1);
  assign sumv = 64'(h_t[11]) + rnd;
  assign resv = sumv >> shv[5:0];

  assign out_valid = cv[LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      width_error <= ce[LAT-1];
      if (ce[LAT-1] || shv >= 8'd63) begin
        gain <= '0;
      end else begin
        gain <= resv[GAIN_FRAC_BITS:0];
      end
    end
  end

endmodule

[hdl/elliptical_gaussian_beam_gain.sv]
// Top level of the elliptical Gaussian beam gain pipeline.
//
//  channel   dir  handshake     payload
//  request   in   valid/ready   position_angle, offset_distance, frequency_hz
//  result    out  valid/ready   gain, width_error
//  cfg       in   cfg_write     cfg_index, cfg_data
//
// One request per cycle unless a held result stalls the pipe; each request passes
// through the 40-step width divider and then the two 32-step offset dividers.
// Reset clears the valid bits and loads the register defaults.
// While a result waits on result.ready, every stage holds and request.ready is low.
module elliptical_gaussian_beam_gain #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ebg_in_if.sink      request,
  ebg_out_if.source   result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ebg_pkg::*;

  cfg_t  cfg;
  logic  en;
  item_t in_item;
  logic  v_fw, v_tr, v_zd;
  item_t i_fw, i_tr, i_zd;
  logic  out_valid;
  logic [GAIN_FRAC_BITS:0] gain;
  logic  width_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aperture <= 32'd786432;
      cfg.wscale   <= 20'd65536;
      cfg.kscale   <= 20'd181704;
      cfg.sigx     <= '0;
      cfg.sigy     <= '0;
      cfg.rot      <= '0;
      cfg.cx       <= '0;
      cfg.cy       <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_APERTURE:      cfg.aperture <= cfg_data;
        REG_WIDTH_SCALING: cfg.wscale   <= cfg_data[19:0];
        REG_EXP_SCALING:   cfg.kscale   <= cfg_data[19:0];
        REG_SIGMA_X:       cfg.sigx     <= cfg_data;
        REG_SIGMA_Y:       cfg.sigy     <= cfg_data;
        REG_ROTATION:      cfg.rot      <= cfg_data[15:0];
        REG_CENTRE_X:      cfg.cx       <= cfg_data;
        REG_CENTRE_Y:      cfg.cy       <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless a finished result is held
  assign en            = !out_valid || result.ready;
  assign request.ready = en;

  always_comb begin
    in_item      = '0;
    in_item.pa   = request.position_angle;
    in_item.offs = request.offset_distance;
    in_item.freq = request.frequency_hz;
  end

  ebg_fwhm u_fwhm (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(request.valid), .in_item(in_item),
    .out_valid(v_fw), .out_item(i_fw)
  );

  ebg_trig u_trig (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_fw), .in_item(i_fw),
    .out_valid(v_tr), .out_item(i_tr)
  );

  ebg_zdiv u_zdiv (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_tr), .in_item(i_tr),
    .out_valid(v_zd), .out_item(i_zd)
  );

  ebg_exp #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_exp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_zd), .in_item(i_zd),
    .out_valid(out_valid), .gain(gain), .width_error(width_error)
  );

  assign result.valid       = out_valid;
  assign result.gain        = gain;
  assign result.width_error = width_error;

endmodule

[tb/elliptical_gaussian_beam_gain_tb.sv]
// Self-checking testbench for the elliptical Gaussian beam gain pipeline.
`timescale 1ns / 1ps

module elliptical_gaussian_beam_gain_tb;
  import ebg_pkg::*;

  typedef struct {
    logic [15:0] pa;
    logic [31:0] offs;
    logic [35:0] freq;
  } request_t;

  typedef struct {
    logic [16:0] gain;
    logic        err;
  } gain_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ebg_in_if  request ();
  ebg_out_if #(.GAIN_FRAC_BITS(16)) result ();

  elliptical_gaussian_beam_gain #(.GAIN_FRAC_BITS(16)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .request   (request.sink),
    .result    (result.source),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  request_t pending_requests[$];
  gain_t    expected_gains[$];
  cfg_t     shadow;
  int       mismatches = 0;
  int       requests_taken = 0;
  int       send_idle, recv_idle;
  request_t next_req;

  initial begin
    request.valid = 1'b0;
    request.position_angle = '0;
    request.offset_distance = '0;
    request.frequency_hz = '0;
    result.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned quarter_sine(longint unsigned p);
    longint unsigned x, x2, t, a, s;
    x = (p * HALF_PI_Q30 + 64'd8192) >> 14;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int m = 6; m >= 1; m--) begin
      a = (x2 * t) >> 30;
      t = (64'd1 << 30) - a / longint'((2 * m) * (2 * m + 1));
    end
    s = (x * t) >> 30;
    return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
  endfunction

  function automatic longint turn_sine(logic [15:0] theta);
    logic [1:0]  q;
    logic [13:0] r;
    longint      mag;
    q = theta[15:14];
    r = theta[13:0];
    mag = longint'(quarter_sine(q[0] ? 64'd16384 - r : 64'(r)));
    return q[1] ? -mag : mag;
  endfunction

  function automatic longint unsigned axis_offset(logic [31:0] offs, longint trig,
                                                  logic [31:0] centre);
    longint unsigned mag;
    longint          proj, diff;
    mag = (trig < 0) ? longint'(-trig) : trig;
    proj = longint'((64'(offs) * mag) >> 30);
    if (trig < 0) proj = -proj;
    diff = proj - longint'($signed(centre));
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic longint unsigned axis_width(logic [31:0] sigma, logic [35:0] freq);
    logic [127:0] q;
    if (sigma != 0) return (64'(sigma) * FWHM_PER_SIGMA_Q30) >> 30;
    if (freq == 0 || shadow.aperture == 0) return 0;
    q = (128'(shadow.wscale) * LIGHT_SPEED) << 30;
    q = q / shadow.aperture;
    q = q / freq;
    if (q > 128'(FW_CAP)) return 64'(FW_CAP);
    return q[63:0];
  endfunction

  function automatic longint unsigned axis_exponent(longint unsigned d,
                                                    longint unsigned fw);
    longint unsigned u, w;
    logic [127:0]    wk;
    if (shadow.kscale == 0) return 0;
    u = (d << 20) / fw;
    if (u >= (64'd1 << 32)) return 64'd32 << 32;
    w = (u * u) >> 8;
    wk = 128'(w) * shadow.kscale;
    if (wk[127:64] != 0) return 64'd32 << 32;
    wk = wk >> 16;
    return (wk > (128'd32 << 32)) ? 64'd32 << 32 : wk[63:0];
  endfunction

  function automatic gain_t beam_gain(request_t rq);
    gain_t           g;
    logic [15:0]     theta;
    longint unsigned dx, dy, fx, fy, zsum, n, r, t, shift, v;
    theta = rq.pa - shadow.rot;
    dx = axis_offset(rq.offs, turn_sine(theta + 16'd16384), shadow.cx);
    dy = axis_offset(rq.offs, turn_sine(theta), shadow.cy);
    fx = axis_width(shadow.sigx, rq.freq);
    fy = axis_width(shadow.sigy, rq.freq);
    if (fx == 0 || fy == 0) begin
      g.gain = '0;
      g.err = 1'b1;
      return g;
    end
    zsum = axis_exponent(dx, fx) + axis_exponent(dy, fy);
    n = zsum / LN2_Q32;
    r = zsum - n * LN2_Q32;
    t = 64'd1 << 32;
    for (int i = 12; i >= 1; i--) t = (64'd1 << 32) - ((r * t) >> 32) / longint'(i);
    shift = 16 + n;
    v = (shift >= 63) ? 0 : (t + (64'd1 << (shift - 1))) >> shift;
    g.gain = v[16:0];
    g.err = 1'b0;
    return g;
  endfunction

  // ---------------- driver, sink and monitor ----------------
  always @(posedge clk) begin
    if (requests_taken < 350) begin
      send_idle <= 7;
      recv_idle <= 81;
    end else if (requests_taken < 700) begin
      send_idle <= 81;
      recv_idle <= 7;
    end else begin
      send_idle <= 0;
      recv_idle <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      request.valid <= 1'b0;
    end else if (!request.valid || request.ready) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        next_req = pending_requests.pop_front();
        request.valid <= 1'b1;
        request.position_angle <= next_req.pa;
        request.offset_distance <= next_req.offs;
        request.frequency_hz <= next_req.freq;
      end else begin
        request.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    request_t rq;
    gain_t    want;
    if (!rst && request.valid && request.ready) begin
      rq.pa = request.position_angle;
      rq.offs = request.offset_distance;
      rq.freq = request.frequency_hz;
      expected_gains.push_back(beam_gain(rq));
      requests_taken++;
    end
    if (!rst && result.valid && result.ready) begin
      if (expected_gains.size() == 0) begin
        report_mismatch("unexpected result, gain", result.gain, 0);
      end else begin
        want = expected_gains.pop_front();
        if (result.gain !== want.gain) report_mismatch("gain", result.gain, want.gain);
        if (result.width_error !== want.err)
          report_mismatch("width_error", result.width_error, want.err);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_APERTURE:      shadow.aperture = value;
      REG_WIDTH_SCALING: shadow.wscale = value[19:0];
      REG_EXP_SCALING:   shadow.kscale = value[19:0];
      REG_SIGMA_X:       shadow.sigx = value;
      REG_SIGMA_Y:       shadow.sigy = value;
      REG_ROTATION:      shadow.rot = value[15:0];
      REG_CENTRE_X:      shadow.cx = value;
      REG_CENTRE_Y:      shadow.cy = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_request(logic [15:0] pa, logic [31:0] offs, logic [35:0] freq);
    request_t rq;
    rq.pa = pa;
    rq.offs = offs;
    rq.freq = freq;
    pending_requests.push_back(rq);
  endtask

  // mostly plausible radio frequencies and offsets near the beam, some raw noise
  task automatic add_random_requests(int count);
    logic [35:0] f;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       f = {4'($urandom_range(0, 15)), $urandom()};
        1:       f = 36'd0;
        2:       f = {4'($urandom_range(0, 15)), $urandom()} >> $urandom_range(0, 35);
        default: f = 36'(longint'($urandom_range(50_000, 20_000_000)) * 1000);
      endcase
      add_request(16'($urandom()), $urandom() >> $urandom_range(0, 31), f);
    end
  endtask

  // sample between edges so every queue and handshake update has settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_requests.size() > 0 || request.valid || expected_gains.size() > 0)
      @(negedge clk);
  endtask

  task automatic random_config();
    write_reg(REG_APERTURE, $urandom_range(1, 32) << $urandom_range(10, 20));
    write_reg(REG_WIDTH_SCALING, $urandom_range(1, 1048575) >> $urandom_range(0, 6));
    write_reg(REG_EXP_SCALING, $urandom_range(0, 1048575) >> $urandom_range(0, 8));
    write_reg(REG_SIGMA_X, ($urandom_range(0, 1)) ? 0 : $urandom() >> $urandom_range(4, 31));
    write_reg(REG_SIGMA_Y, ($urandom_range(0, 1)) ? 0 : $urandom() >> $urandom_range(4, 31));
    write_reg(REG_ROTATION, $urandom_range(0, 65535));
    write_reg(REG_CENTRE_X, $signed($urandom()) >>> $urandom_range(4, 31));
    write_reg(REG_CENTRE_Y, $signed($urandom()) >>> $urandom_range(4, 31));
  endtask

  initial begin
    shadow.aperture = 32'd786432;
    shadow.wscale = 20'd65536;
    shadow.kscale = 20'd181704;
    shadow.sigx = '0;
    shadow.sigy = '0;
    shadow.rot = '0;
    shadow.cx = '0;
    shadow.cy = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    add_request(16'd0, 32'd0, 36'd1_000_000_000);
    add_request(16'd16384, 32'd10_000_000, 36'd1_400_000_000);
    add_request(16'd32768, 32'd30_000_000, 36'd1_400_000_000);
    add_request(16'd49152, 32'd20_000_000, 36'd700_000_000);
    add_request(16'd65535, 32'hFFFF_FFFF, 36'd1_000_000_000);
    add_request(16'd8192, 32'd5_000_000, 36'd0);
    add_request(16'd12345, 32'd1_000_000, 36'hF_FFFF_FFFF);
    add_request(16'd1, 32'd1, 36'd1);
    add_request(16'hAAAA, 32'h5555_5555, 36'hA_AAAA_AAAA);
    add_request(16'h5555, 32'hAAAA_AAAA, 36'h5_5555_5555);
    wait_idle();

    // extremes: huge aperture, tiny scaling makes the width truncate to zero at the top frequency
    write_reg(REG_APERTURE, 32'hFFFF_FFFF);
    write_reg(REG_WIDTH_SCALING, 32'd1);
    write_reg(REG_EXP_SCALING, 32'hF_FFFF);
    write_reg(REG_ROTATION, 32'hFFFF);
    write_reg(REG_CENTRE_X, 32'h8000_0000);
    write_reg(REG_CENTRE_Y, 32'h7FFF_FFFF);
    add_request(16'd100, 32'd1000, 36'hF_FFFF_FFFF);
    add_request(16'd200, 32'd1000, 36'd1);
    wait_idle();
    write_reg(REG_SIGMA_X, 32'hFFFF_FFFF);
    write_reg(REG_SIGMA_Y, 32'd1);
    add_request(16'd300, 32'hFFFF_FFFF, 36'd0);
    add_request(16'd40000, 32'd0, 36'd5);
    wait_idle();
    write_reg(REG_APERTURE, 32'd1);
    write_reg(REG_WIDTH_SCALING, 32'hF_FFFF);
    write_reg(REG_EXP_SCALING, 32'd0);
    write_reg(REG_SIGMA_X, 32'd0);
    write_reg(REG_SIGMA_Y, 32'd0);
    write_reg(REG_ROTATION, 32'd0);
    write_reg(REG_CENTRE_X, 32'd0);
    write_reg(REG_CENTRE_Y, 32'd0);
    add_request(16'd777, 32'd123456, 36'd1);
    add_request(16'd778, 32'hFFFF_FFFF, 36'hF_FFFF_FFFF);
    wait_idle();
    write_reg(REG_WIDTH_SCALING, 32'd0);
    add_request(16'd779, 32'd1000, 36'd1_000_000_000);
    wait_idle();

    // back to defaults for the first random stretch
    write_reg(REG_APERTURE, 32'd786432);
    write_reg(REG_WIDTH_SCALING, 32'd65536);
    write_reg(REG_EXP_SCALING, 32'd181704);
    add_random_requests(150);
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      add_random_requests(150);
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_gains.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[elliptical_gaussian_beam_gain.f]
hdl/ebg_pkg.sv
hdl/ebg_if.sv
hdl/ebg_fwhm.sv
hdl/ebg_trig.sv
hdl/ebg_zdiv.sv
hdl/ebg_exp.sv
hdl/elliptical_gaussian_beam_gain.sv
tb/elliptical_gaussian_beam_gain_tb.sv
